@@ rtl/core/serp_pkg.sv @@
// Serpent package: S-box tables, state enum, linear transforms.
`default_nettype none
package serp_pkg;
    localparam logic [31:0] PHI = 32'h9e3779b9;
    localparam int STORE_DEPTH = 132;

    localparam logic [2:0] CFG_KEY0 = 3'd0;
    localparam logic [2:0] CFG_KEY1 = 3'd1;
    localparam logic [2:0] CFG_KEY2 = 3'd2;
    localparam logic [2:0] CFG_KEY3 = 3'd3;
    localparam logic [2:0] CFG_KLEN = 3'd4;

    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEXP,
        ST_KSUB,
        ST_ROUND,
        ST_DONE
    } state_t;

    typedef logic [3:0] nib_t;

    function automatic nib_t sbox_fwd(input logic [2:0] b, input nib_t n);
        logic [63:0] row;
        unique case (b)
            3'd0: row = 64'hc907_24de_b56a_1f83;
            3'd1: row = 64'h43d6_8eb1_a509_72cf;
            3'd2: row = 64'h25b0_4e1d_fac3_9768;
            3'd3: row = 64'he57a_421d_369c_8bf0;
            3'd4: row = 64'hd7e9_a452_6b0c_38f1;
            3'd5: row = 64'h176d_8e30_c9a4_b25f;
            3'd6: row = 64'h0a3d_f19e_b648_5c27;
            default: row = 64'h6539_ac47_b28e_0fd1;
        endcase
        return row[{n, 2'b00} +: 4];
    endfunction

    function automatic nib_t sbox_rev(input logic [2:0] b, input nib_t n);
        logic [63:0] row;
        unique case (b)
            3'd0: row = 64'h289f_74e1_c56a_0b3d;
            3'd1: row = 64'h0ad1_974b_3c6f_e285;
            3'd2: row = 64'h7a85_d630_21eb_4f9c;
            3'd3: row = 64'h1f84_2c53_d6eb_7a90;
            3'd4: row = 64'h1df4_6bc2_e79a_3805;
            3'd5: row = 64'h0ac7_356b_ed14_92f8;
            3'd6: row = 64'hb8c2_7e94_0635_d1af;
            default: row = 64'h241a_7bc5_8fe9_d603;
        endcase
        return row[{n, 2'b00} +: 4];
    endfunction

    function automatic logic [127:0] slice(input logic [127:0] x, input logic [2:0] b,
                                           input logic rev);
        logic [127:0] y;
        nib_t n;
        nib_t v;
        y = '0;
        for (int j = 0; j < 32; j++)
        begin
            n = {x[96 + j], x[64 + j], x[32 + j], x[j]};
            v = rev ? sbox_rev(b, n) : sbox_fwd(b, n);
            y[j] = v[0];
            y[32 + j] = v[1];
            y[64 + j] = v[2];
            y[96 + j] = v[3];
        end
        return y;
    endfunction

    function automatic logic [31:0] rl(input logic [31:0] a, input int n);
        return (a << n) | (a >> (32 - n));
    endfunction

    function automatic logic [31:0] rr(input logic [31:0] a, input int n);
        return (a >> n) | (a << (32 - n));
    endfunction

    function automatic logic [127:0] mix_fwd(input logic [127:0] v);
        logic [31:0] x0, x1, x2, x3;
        x0 = v[31:0]; x1 = v[63:32]; x2 = v[95:64]; x3 = v[127:96];
        x0 = rl(x0, 13);
        x2 = rl(x2, 3);
        x1 = x1 ^ x0 ^ x2;
        x3 = x3 ^ x2 ^ (x0 << 3);
        x1 = rl(x1, 1);
        x3 = rl(x3, 7);
        x0 = x0 ^ x1 ^ x3;
        x2 = x2 ^ x3 ^ (x1 << 7);
        x0 = rl(x0, 5);
        x2 = rl(x2, 22);
        return {x3, x2, x1, x0};
    endfunction

    function automatic logic [127:0] mix_rev(input logic [127:0] v);
        logic [31:0] x0, x1, x2, x3;
        x0 = v[31:0]; x1 = v[63:32]; x2 = v[95:64]; x3 = v[127:96];
        x2 = rr(x2, 22);
        x0 = rr(x0, 5);
        x2 = x2 ^ x3 ^ (x1 << 7);
        x0 = x0 ^ x1 ^ x3;
        x3 = rr(x3, 7);
        x1 = rr(x1, 1);
        x3 = x3 ^ x2 ^ (x0 << 3);
        x1 = x1 ^ x0 ^ x2;
        x2 = rr(x2, 3);
        x0 = rr(x0, 13);
        return {x3, x2, x1, x0};
    endfunction
endpackage
`default_nettype wire

@@ rtl/core/serp_round.sv @@
// Serpent round: key mix, S-boxes, linear transform (not last round).
`default_nettype none
module serp_round
(
    input  wire logic [127:0] x,
    input  wire logic [127:0] rkey,
    input  wire logic [2:0]   box,
    input  wire logic         rev,
    input  wire logic         is_last,
    output logic [127:0]      y
);
    import serp_pkg::*;
    logic [127:0] t;
    always_comb
    begin
        if (!rev)
        begin
            t = slice(x ^ rkey, box, 1'b0);
            y = is_last ? t : mix_fwd(t);
        end
        else
        begin
            t = is_last ? x : mix_rev(x);
            y = slice(t, box, 1'b1) ^ rkey;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/serpent_block_cipher_top.sv @@
// Serpent block cipher top level: key expansion, round sequencer, output register.
`default_nettype none
// Round-iterative Serpent core. One round runs per cycle through one shared round
// unit, with the 128-bit round key prefetched from a (ROUNDS+1)-row key memory
// through its registered read port. An encrypt block runs ROUNDS rounds, then the
// final key mix into the output register; a decrypt block adds a leading key mix.
// The first block after any write to a key word or the key length first expands
// the key: for each of the ROUNDS+1 rows, four prekey words one per cycle and then
// one S-box pass, followed by a fetch of the first row. The result is held in an
// output register; the next block is accepted from the cycle after the result has
// been taken.
module serpent_block_cipher_top #(
    parameter int ROUNDS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        opcode,
    input  wire logic [63:0] block_high,
    input  wire logic [63:0] block_low,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      result_high,
    output logic [63:0]      result_low
);
    import serp_pkg::*;

    localparam int ROWS = ROUNDS + 1;
    localparam int RW = $clog2(ROWS + 1);
    localparam int PW = $clog2(4 * ROWS + 1);

    logic [63:0] key_reg [4];
    logic [1:0]  klen_reg;
    logic        kready_reg, kready_next;
    state_t      state_reg, state_next;

    logic [127:0] kmem [ROWS];
    logic [127:0] kmem_rd_reg;
    logic [RW-1:0] raddr;
    logic [255:0] win_reg, win_next;
    logic [PW-1:0] pcnt_reg, pcnt_next;
    logic [127:0] prow_reg, prow_next;
    logic [RW-1:0] rcnt_reg, rcnt_next;
    logic         op_reg, op_next;
    logic [127:0] x_reg, x_next;
    logic [127:0] out_reg, out_next;
    logic         ov_reg, ov_next;
    logic         we_mem;
    logic [RW-1:0] waddr;
    logic [127:0] wdata;
    logic [127:0] rnd_y;
    logic [2:0]   rbox;
    logic         rlast;
    logic [31:0]  pw_new;
    logic [255:0] kinit;
    logic [RW-1:0] rsel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                key_reg[i] <= '0;
            klen_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KEY0: key_reg[0] <= cfg_data;
                CFG_KEY1: key_reg[1] <= cfg_data;
                CFG_KEY2: key_reg[2] <= cfg_data;
                CFG_KEY3: key_reg[3] <= cfg_data;
                CFG_KLEN: klen_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        kinit = {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};
        unique case (klen_reg)
            2'd0: kinit[255:128] = 128'd1;
            2'd1: kinit[255:192] = 64'd1;
            default: ;
        endcase
    end

    assign pw_new = rl(win_reg[31:0] ^ win_reg[127:96] ^ win_reg[191:160]
                       ^ win_reg[255:224] ^ PHI ^ 32'(pcnt_reg), 11);

    // round index: encrypt counts up from 0, decrypt counts down from ROUNDS
    assign rsel = op_reg ? RW'(ROUNDS) - rcnt_reg : rcnt_reg;
    assign rbox = 3'(rsel);
    assign rlast = (rcnt_reg == RW'(0));

    always_comb
    begin
        priority if (state_reg == ST_KEXP || state_reg == ST_KSUB)
            raddr = rcnt_reg;
        else if (state_reg == ST_ROUND)
            raddr = op_reg ? RW'(ROUNDS - 1) - rcnt_reg : rcnt_reg + RW'(1);
        else if (state_reg == ST_DONE)
            raddr = op_reg ? RW'(ROUNDS) : RW'(0);
        else
            raddr = in_valid && opcode ? RW'(ROUNDS) : RW'(0);
    end

    always_ff @(posedge clk)
    begin
        if (we_mem)
            kmem[waddr] <= wdata;
        kmem_rd_reg <= kmem[raddr[RW-1:0]];
    end

    serp_round u_round (
        .x      (x_reg),
        .rkey   (kmem_rd_reg),
        .box    (rbox),
        .rev    (op_reg),
        .is_last(op_reg ? (rcnt_reg == RW'(1)) : (rcnt_reg == RW'(ROUNDS - 1))),
        .y      (rnd_y)
    );

    always_comb
    begin
        state_next = state_reg;
        kready_next = kready_reg;
        win_next = win_reg;
        pcnt_next = pcnt_reg;
        prow_next = prow_reg;
        rcnt_next = rcnt_reg;
        op_next = op_reg;
        x_next = x_reg;
        out_next = out_reg;
        ov_next = ov_reg;
        we_mem = 1'b0;
        waddr = rcnt_reg;
        wdata = prow_reg;
        in_ready = 1'b0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = !ov_reg;
                if (in_valid && !ov_reg)
                begin
                    op_next = opcode;
                    x_next = {block_high, block_low};
                    rcnt_next = '0;
                    if (kready_reg)
                        state_next = ST_ROUND;
                    else
                    begin
                        state_next = ST_KEXP;
                        win_next = kinit;
                        pcnt_next = '0;
                    end
                end
            end
            ST_KEXP:
            begin
                win_next = {pw_new, win_reg[255:32]};
                prow_next = {pw_new, prow_reg[127:32]};
                pcnt_next = pcnt_reg + PW'(1);
                if (pcnt_reg[1:0] == 2'd3)
                begin
                    state_next = ST_KSUB;
                end
            end
            ST_KSUB:
            begin
                we_mem = 1'b1;
                wdata = slice(prow_reg, 3'(RW'(3) - rcnt_reg), 1'b0);
                rcnt_next = rcnt_reg + RW'(1);
                if (rcnt_reg == RW'(ROUNDS))
                begin
                    kready_next = 1'b1;
                    rcnt_next = '0;
                    state_next = ST_DONE;
                end
                else
                    state_next = ST_KEXP;
            end
            ST_DONE:
            begin
                // prefetch first key row for the held block
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (rlast && op_reg)
                begin
                    x_next = x_reg ^ kmem_rd_reg;
                    rcnt_next = rcnt_reg + RW'(1);
                end
                else if (op_reg ? (rcnt_reg == RW'(ROUNDS + 1)) : (rcnt_reg == RW'(ROUNDS)))
                begin
                    out_next = op_reg ? x_reg : x_reg ^ kmem_rd_reg;
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    x_next = rnd_y;
                    rcnt_next = rcnt_reg + RW'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_we && cfg_index <= CFG_KLEN)
            kready_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kready_reg <= 1'b0;
            ov_reg <= 1'b0;
            rcnt_reg <= '0;
            pcnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kready_reg <= kready_next;
            ov_reg <= ov_next;
            rcnt_reg <= rcnt_next;
            pcnt_reg <= pcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        prow_reg <= prow_next;
        op_reg <= op_next;
        x_reg <= x_next;
        out_reg <= out_next;
    end

    assign out_valid = ov_reg;
    assign result_high = out_reg[127:64];
    assign result_low = out_reg[63:0];
endmodule
`default_nettype wire

@@ rtl/core/serp_checker.sv @@
// Port-level checker for the Serpent top level, with its bind.
`default_nettype none
module serp_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] result_high,
    input wire logic [63:0] result_low
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_high) && $stable(result_low))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accept");
    a_no_acc_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("accepting while result pending");
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> ##1 !out_valid)
        else $error("result too early");
endmodule

bind serpent_block_cipher_top serp_checker u_serp_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_high(result_high), .result_low(result_low)
);
`default_nettype wire
